// ===== hdl/lisp_token_lexer_macros.svh =====
// ----------------------------------------------------------------------------
// Lexer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LISP_TOKEN_LEXER_MACROS_SVH
`define LISP_TOKEN_LEXER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LTL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LTL_ASSERT_IMP(name, ante, cons, msg) \
	`LTL_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ===== hdl/ltl_pkg.sv =====
// ----------------------------------------------------------------------------
// Lexer package
// Sizes, codes, character classes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ltl_pkg;

	localparam int TOKEN_MAX = 32;
	localparam int LINE_MAX  = 1024;

	localparam int LEN_W = $clog2(TOKEN_MAX + 1);
	localparam int IDX_W = $clog2(TOKEN_MAX);
	localparam int CNT_W = $clog2(LINE_MAX + 1);
	localparam int COL_W = 11;

	// token types
	localparam logic [2:0] TT_ERROR   = 3'd0;
	localparam logic [2:0] TT_INTEGER = 3'd1;
	localparam logic [2:0] TT_STRING  = 3'd2;
	localparam logic [2:0] TT_SYMBOL  = 3'd3;
	localparam logic [2:0] TT_EOL     = 3'd4;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X_LO   = 8'h78;

	// escape results
	localparam logic [7:0] ESC_BEL = 8'd7;
	localparam logic [7:0] ESC_BS  = 8'd8;
	localparam logic [7:0] ESC_HT  = 8'd9;
	localparam logic [7:0] ESC_LF  = 8'd10;
	localparam logic [7:0] ESC_VT  = 8'd11;
	localparam logic [7:0] ESC_FF  = 8'd12;
	localparam logic [7:0] ESC_CR  = 8'd13;

	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_LEX  = 5'b00010,
		PH_EVAL = 5'b00100,
		PH_EMIT = 5'b01000,
		PH_MARK = 5'b10000
	} phase_t;

	typedef enum logic [8:0] {
		LM_IDLE    = 9'b000000001,
		LM_MINUS   = 9'b000000010,
		LM_SYMBOL  = 9'b000000100,
		LM_DECIMAL = 9'b000001000,
		LM_ZPREFIX = 9'b000010000,
		LM_HPREFIX = 9'b000100000,
		LM_HEX     = 9'b001000000,
		LM_STRING  = 9'b010000000,
		LM_ESCAPE  = 9'b100000000
	} lex_mode_t;

	typedef struct packed {
		logic             take;
		logic             push;
		logic [7:0]       push_char;
		logic             emit_start;
		logic [2:0]       emit_type;
		logic             col_before;
		logic             eval_step;
		logic             idx_clr;
		logic             emit_step;
		logic             mark;
	} cmd_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       ch;
		logic [LEN_W-1:0] len;
		logic             full;
		logic             eval_done;
		logic             emit_last;
		logic             out_ready;
	} status_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (is_digit(c)) v = c - 8'h30;
		else if (c >= 8'h61) v = c - 8'h57;
		else v = c - 8'h37;
		return v[3:0];
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_sym_start(input logic [7:0] c);
		return is_alpha(c) || c == 8'h2B || c == 8'h2F || c == 8'h2A || c == 8'h3C ||
			c == 8'h3D || c == 8'h3E;
	endfunction

	function automatic logic in_sym_set(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h21 || c == 8'h26 || c == 8'h2A ||
			c == 8'h2B || c == CH_MINUS || c == 8'h3C || c == 8'h3D || c == 8'h3E ||
			c == 8'h3F || c == 8'h40;
	endfunction

endpackage

// ===== hdl/lisp_token_lexer.sv =====
// ----------------------------------------------------------------------------
// Lisp token lexer
// Streams one line of Lisp-like text a character per transaction (kind 0) and
// closes the line with an end-of-line transaction (kind 1). Each completed
// token leaves as a run of result transactions, one per token character, all
// carrying the token type, its saturated 32-bit value (integers only) and the
// column at which it completed; last marks the final one, and an empty string
// gives a single result with char_present low. End of line flushes a pending
// token and then sends an end marker. Each character is accepted and then lexed
// in a pass, with a further pass when a symbol ends on a character that is
// lexed again, a minus meets a symbol start or a string escape falls through.
// A completed token is read out one buffered character per result, and an
// integer token is first evaluated one character per step, since the
// value is built by sweeping the token buffer through its single read port.
// Output stall only lengthens the read-out phase; the next character is taken
// as soon as the last result sits in the output register.
// ----------------------------------------------------------------------------
module lisp_token_lexer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [7:0]                char_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                tok_class,
	output logic [7:0]                char_out,
	output logic                      char_present,
	output logic signed [31:0]        int_value,
	output logic [ltl_pkg::COL_W-1:0] column,
	output logic                      last
);
	import ltl_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller: phase sequencing and lexer mode
	ltl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: buffer, counters, value sweep, output register
	ltl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.char_in      (char_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tok_class    (tok_class),
		.char_out     (char_out),
		.char_present (char_present),
		.int_value    (int_value),
		.column       (column),
		.last         (last)
	);

endmodule

// ===== hdl/ltl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lexer controller
// Sequencing phases and the lexer mode machine; drives datapath commands.
// ----------------------------------------------------------------------------
module ltl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ltl_pkg::status_t st,
	output ltl_pkg::cmd_t   cmd
);
	import ltl_pkg::*;

	phase_t    phase_q, phase_d, next_q, next_d;
	lex_mode_t mode_q, mode_d;

	// result of one lexing pass
	logic       p_push, p_must, p_emit, p_before, p_redo;
	logic [7:0] p_char;
	logic [2:0] p_type;
	lex_mode_t  p_mode;
	logic       fail;
	logic [2:0] eol_type;
	logic [7:0] c;

	assign c = st.ch;

	always_comb begin
		p_push = 1'b0;
		p_must = 1'b0;
		p_emit = 1'b0;
		p_before = 1'b0;
		p_redo = 1'b0;
		p_char = c;
		p_type = TT_ERROR;
		p_mode = mode_q;
		unique case (mode_q)
			LM_IDLE: begin
				priority if (c == CH_QUOTE) begin
					p_mode = LM_STRING;
				end else if (c == CH_ZERO) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_ZPREFIX;
				end else if (is_digit(c)) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_DECIMAL;
				end else if (is_sym_start(c) || c == 8'h26) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_SYMBOL;
				end else if (c == CH_MINUS) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_MINUS;
				end else if (c == CH_HASH) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_HPREFIX;
				end else if (!is_term(c)) begin
					p_push = 1'b1; p_emit = 1'b1;
				end else begin
					p_mode = LM_IDLE;
				end
			end
			LM_MINUS: begin
				priority if (is_digit(c)) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_DECIMAL;
				end else if (is_sym_start(c)) begin
					p_mode = LM_SYMBOL; p_redo = 1'b1;
				end else if (is_blank(c)) begin
					p_emit = 1'b1; p_type = TT_SYMBOL;
				end else begin
					p_push = 1'b1; p_emit = 1'b1;
				end
			end
			LM_ZPREFIX, LM_HPREFIX: begin
				priority if (c == CH_X_LO || c == CH_X_UP) begin
					p_push = 1'b1; p_must = 1'b1;
				end else if (is_hex(c)) begin
					p_push = 1'b1; p_must = 1'b1; p_mode = LM_HEX;
				end else if (mode_q == LM_ZPREFIX && st.len == LEN_W'(1) && is_term(c)) begin
					p_emit = 1'b1; p_type = TT_INTEGER;
				end else begin
					p_push = 1'b1; p_emit = 1'b1;
				end
			end
			LM_DECIMAL, LM_HEX: begin
				priority if (is_term(c)) begin
					p_emit = 1'b1; p_type = TT_INTEGER;
				end else if (mode_q == LM_DECIMAL ? is_digit(c) : is_hex(c)) begin
					p_push = 1'b1; p_must = 1'b1;
				end else begin
					p_push = 1'b1; p_emit = 1'b1;
				end
			end
			LM_STRING: begin
				priority if (c == CH_QUOTE) begin
					p_emit = 1'b1; p_type = TT_STRING;
				end else if (c == CH_BSLASH) begin
					p_mode = LM_ESCAPE;
				end else begin
					p_push = 1'b1; p_must = 1'b1;
				end
			end
			LM_ESCAPE: begin
				p_mode = LM_STRING;
				p_must = 1'b1;
				unique case (c)
					CH_LF: p_must = 1'b0;
					CH_BSLASH, CH_QUOTE: p_push = 1'b1;
					8'h61: begin p_push = 1'b1; p_char = ESC_BEL; end
					8'h62: begin p_push = 1'b1; p_char = ESC_BS; end
					8'h66: begin p_push = 1'b1; p_char = ESC_FF; end
					8'h6E: begin p_push = 1'b1; p_char = ESC_LF; end
					8'h72: begin p_push = 1'b1; p_char = ESC_CR; end
					8'h74: begin p_push = 1'b1; p_char = ESC_HT; end
					8'h76: begin p_push = 1'b1; p_char = ESC_VT; end
					default: begin p_push = 1'b1; p_char = CH_BSLASH; p_redo = 1'b1; end
				endcase
			end
			LM_SYMBOL: begin
				if (in_sym_set(c)) begin
					p_push = 1'b1; p_must = 1'b1;
				end else begin
					p_emit = 1'b1; p_type = TT_SYMBOL; p_before = 1'b1; p_redo = 1'b1;
				end
			end
			default: p_mode = LM_IDLE;
		endcase
	end

	assign fail = p_push && p_must && st.full;

	always_comb begin
		unique case (mode_q)
			LM_DECIMAL, LM_HEX:  eol_type = TT_INTEGER;
			LM_SYMBOL, LM_MINUS: eol_type = TT_SYMBOL;
			LM_ZPREFIX:          eol_type = (st.len == LEN_W'(1)) ? TT_INTEGER : TT_ERROR;
			default:             eol_type = TT_ERROR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.push_char = p_char;
		phase_d = phase_q;
		mode_d = mode_q;
		next_d = next_q;
		unique case (phase_q)
			PH_WAIT: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					phase_d = PH_LEX;
				end
			end
			PH_LEX: begin
				if (st.kind) begin
					if (mode_q == LM_IDLE) begin
						phase_d = PH_MARK;
					end else begin
						cmd.emit_start = 1'b1;
						cmd.emit_type = eol_type;
						mode_d = LM_IDLE;
						next_d = PH_MARK;
						phase_d = (eol_type == TT_INTEGER) ? PH_EVAL : PH_EMIT;
					end
				end else begin
					cmd.push = p_push && !st.full;
					if (p_emit || fail) begin
						cmd.emit_start = 1'b1;
						cmd.emit_type = fail ? TT_ERROR : p_type;
						cmd.col_before = p_before && !fail;
						mode_d = LM_IDLE;
						next_d = (p_redo && !fail) ? PH_LEX : PH_WAIT;
						phase_d = (!fail && p_type == TT_INTEGER) ? PH_EVAL : PH_EMIT;
					end else begin
						mode_d = p_mode;
						phase_d = p_redo ? PH_LEX : PH_WAIT;
					end
				end
			end
			PH_EVAL: begin
				if (st.eval_done) begin
					cmd.idx_clr = 1'b1;
					phase_d = PH_EMIT;
				end else begin
					cmd.eval_step = 1'b1;
				end
			end
			PH_EMIT: begin
				if (st.out_ready) begin
					cmd.emit_step = 1'b1;
					if (st.emit_last) phase_d = next_q;
				end
			end
			PH_MARK: begin
				if (st.out_ready) begin
					cmd.mark = 1'b1;
					mode_d = LM_IDLE;
					phase_d = PH_WAIT;
				end
			end
			default: phase_d = PH_WAIT;
		endcase
	end

	assign in_stall = (phase_q != PH_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			next_q <= PH_WAIT;
			mode_q <= LM_IDLE;
		end else begin
			phase_q <= phase_d;
			next_q <= next_d;
			mode_q <= mode_d;
		end
	end

endmodule

// ===== hdl/ltl_datapath.sv =====
// ----------------------------------------------------------------------------
// Lexer datapath
// Token buffer, column counter, value evaluation and output register.
// ----------------------------------------------------------------------------
`include "lisp_token_lexer_macros.svh"

module ltl_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ltl_pkg::cmd_t             cmd,
	output ltl_pkg::status_t          st,
	input  logic                      kind,
	input  logic [7:0]                char_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                tok_class,
	output logic [7:0]                char_out,
	output logic                      char_present,
	output logic signed [31:0]        int_value,
	output logic [ltl_pkg::COL_W-1:0] column,
	output logic                      last
);
	import ltl_pkg::*;

	logic             kind_q;
	logic [7:0]       char_q;
	logic [7:0]       buf_q [TOKEN_MAX];
	logic [LEN_W-1:0] len_q, idx_q;
	logic [CNT_W-1:0] count_q, before_q;
	logic [2:0]       type_q;
	logic [COL_W-1:0] col_q;
	logic [31:0]      acc_q;
	logic             neg_q, stop_q;
	logic             out_valid_q, last_q;

	logic             full, out_ready, emit_last, hex_mode;
	logic [7:0]       rd_char;
	logic [35:0]      wide;
	logic [31:0]      acc_cap, sat_val;

	assign full = len_q >= LEN_W'(TOKEN_MAX);
	assign out_ready = !out_valid_q || !out_stall;
	assign rd_char = buf_q[idx_q[IDX_W-1:0]];
	assign emit_last = (len_q == '0) || (idx_q + LEN_W'(1) == len_q);
	assign hex_mode = len_q >= LEN_W'(2) && (buf_q[1] == CH_X_LO || buf_q[1] == CH_X_UP);

	always_comb begin
		st.kind = kind_q;
		st.ch = char_q;
		st.len = len_q;
		st.full = full;
		st.eval_done = idx_q >= len_q;
		st.emit_last = emit_last;
		st.out_ready = out_ready;
	end

	// one digit of the value per step, capped at 2^31
	assign wide = hex_mode ? (({4'b0, acc_q} << 4) + 36'(hex_val(rd_char)))
		: (({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 36'(hex_val(rd_char)));
	assign acc_cap = (wide > 36'h0_8000_0000) ? 32'h8000_0000 : wide[31:0];

	always_comb begin
		if (neg_q) sat_val = (acc_q >= 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - acc_q);
		else sat_val = (acc_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= kind;
			char_q <= char_in;
		end
		if (cmd.push) buf_q[len_q[IDX_W-1:0]] <= cmd.push_char;
		if (cmd.emit_start) begin
			type_q <= cmd.emit_type;
			col_q <= COL_W'(cmd.col_before ? before_q : count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			before_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			if (cmd.take && !kind) begin
				before_q <= count_q;
				if (count_q < CNT_W'(LINE_MAX)) count_q <= count_q + CNT_W'(1);
			end
			if (cmd.push) len_q <= len_q + LEN_W'(1);
			if (cmd.emit_start) begin
				idx_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
				stop_q <= 1'b0;
			end
			if (cmd.idx_clr) idx_q <= '0;
			if (cmd.eval_step) begin
				idx_q <= idx_q + LEN_W'(1);
				if (hex_mode) begin
					if (idx_q >= LEN_W'(2)) begin
						if (!stop_q && is_hex(rd_char)) acc_q <= acc_cap;
						else stop_q <= 1'b1;
					end
				end else begin
					priority if (idx_q == '0 && rd_char == CH_MINUS) neg_q <= 1'b1;
					else if (!stop_q && is_digit(rd_char)) acc_q <= acc_cap;
					else stop_q <= 1'b1;
				end
			end
			if (cmd.emit_step) begin
				idx_q <= idx_q + LEN_W'(1);
				if (emit_last) len_q <= '0;
			end
			if (cmd.mark) begin
				count_q <= '0;
				len_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			tok_class <= type_q;
			char_out <= (len_q == '0) ? 8'h00 : rd_char;
			char_present <= (len_q != '0);
			int_value <= (type_q == TT_INTEGER) ? sat_val : 32'd0;
			column <= col_q;
			last_q <= emit_last;
		end else if (cmd.mark) begin
			tok_class <= TT_EOL;
			char_out <= 8'h00;
			char_present <= 1'b0;
			int_value <= 32'd0;
			column <= COL_W'(count_q);
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit_step || cmd.mark) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign last = last_q;

	`LTL_ASSERT(a_len_bound, len_q <= LEN_W'(TOKEN_MAX), "token length past buffer size")
	`LTL_ASSERT_IMP(a_eol_shape, out_valid_q && tok_class == TT_EOL, last_q && !char_present, "end marker malformed")
	`LTL_ASSERT(a_mark_clears, cmd.mark |=> (count_q == '0 && len_q == '0), "line state not cleared after end marker")
	`LTL_ASSERT_IMP(a_no_overrun, cmd.emit_step || cmd.mark, out_ready, "result loaded over a waiting one")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Lisp token lexer testbench
// Feeds line characters and end-of-line transactions through the valid/stall
// handshake, predicts every token run with a behavioral lexer kept in step
// with the block, and checks each result transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ltl_pkg::*;

	// lexer modes of the predictor
	typedef enum int {
		PM_IDLE, PM_MINUS, PM_SYMBOL, PM_DECIMAL, PM_ZPREFIX,
		PM_HPREFIX, PM_HEX, PM_STRING, PM_ESCAPE
	} pmode_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} lex_item_t;

	typedef struct packed {
		logic [2:0]        tok_class;
		logic [7:0]        char_out;
		logic              char_present;
		logic [31:0]       int_value;
		logic [COL_W-1:0]  column;
		logic              last;
	} token_beat_t;

	logic clk, arst_n;
	logic in_valid, in_stall, kind;
	logic [7:0] char_in;
	logic out_valid, out_stall;
	logic [2:0] tok_class;
	logic [7:0] char_out;
	logic char_present;
	logic signed [31:0] int_value;
	logic [COL_W-1:0] column;
	logic last;

	lisp_token_lexer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .char_in(char_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.tok_class(tok_class), .char_out(char_out),
		.char_present(char_present), .int_value(int_value),
		.column(column), .last(last)
	);

	// Predictor state, mirrors the lexer's architectural state
	pmode_t      lx_mode;
	logic [7:0]  lx_buf [TOKEN_MAX];
	int          lx_len;
	int          lx_col;
	token_beat_t expected_beats [$];

	lex_item_t   pending_items [$];
	int          send_idle_pct, recv_idle_pct;
	bit          hold_sender;
	int          failures, beats_checked, items_sent, tokens_seen;
	int          quiet_cycles;

	localparam int WATCHDOG_LIMIT = 20000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit lx_push(logic [7:0] c);
		if (lx_len >= TOKEN_MAX) return 1'b0;
		lx_buf[lx_len] = c;
		lx_len++;
		return 1'b1;
	endfunction

	// Saturating value of the buffered token, hex when second char is x/X
	function automatic logic [31:0] token_value();
		longint acc;
		int i;
		bit neg, hexv;
		acc = 0;
		i = 0;
		neg = 0;
		hexv = lx_len >= 2 && (lx_buf[1] == CH_X_LO || lx_buf[1] == CH_X_UP);
		if (hexv) begin
			for (i = 2; i < lx_len && is_hex(lx_buf[i]); i++) begin
				acc = acc * 16 + hex_val(lx_buf[i]);
				if (acc > 64'h8000_0000) acc = 64'h8000_0000;
			end
		end else begin
			if (lx_len > 0 && lx_buf[0] == CH_MINUS) begin
				neg = 1;
				i = 1;
			end
			for (; i < lx_len && is_digit(lx_buf[i]); i++) begin
				acc = acc * 10 + (lx_buf[i] - CH_ZERO);
				if (acc > 64'h8000_0000) acc = 64'h8000_0000;
			end
		end
		if (neg) return (acc >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-acc);
		return (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(acc);
	endfunction

	// Queue one run of result transactions for the buffered token
	task automatic emit_token(logic [2:0] tt, int col);
		token_beat_t b;
		logic [31:0] v;
		v = (tt == TT_INTEGER) ? token_value() : 32'd0;
		if (lx_len == 0) begin
			b = '{tt, 8'd0, 1'b0, v, COL_W'(col), 1'b1};
			expected_beats.push_back(b);
		end else begin
			for (int i = 0; i < lx_len; i++) begin
				b = '{tt, lx_buf[i], 1'b1, v, COL_W'(col), 1'(i + 1 == lx_len)};
				expected_beats.push_back(b);
			end
		end
		lx_len = 0;
		lx_mode = PM_IDLE;
	endtask

	task automatic predict_item(lex_item_t it);
		logic [7:0] c;
		int col_prev;
		bit redo, ok;
		token_beat_t b;
		c = it.ch;
		if (it.kind == KIND_EOL) begin
			case (lx_mode)
				PM_IDLE: ;
				PM_DECIMAL, PM_HEX: emit_token(TT_INTEGER, lx_col);
				PM_SYMBOL, PM_MINUS: emit_token(TT_SYMBOL, lx_col);
				PM_ZPREFIX: emit_token(lx_len == 1 ? TT_INTEGER : TT_ERROR, lx_col);
				default: emit_token(TT_ERROR, lx_col);
			endcase
			b = '{TT_EOL, 8'd0, 1'b0, 32'd0, COL_W'(lx_col), 1'b1};
			expected_beats.push_back(b);
			lx_col = 0;
			lx_len = 0;
			lx_mode = PM_IDLE;
			return;
		end
		col_prev = lx_col;
		if (lx_col < LINE_MAX) lx_col++;
		redo = 1;
		for (int pass = 0; redo && pass < 4; pass++) begin
			ok = 1;
			redo = 0;
			case (lx_mode)
				PM_IDLE: begin
					if (c == CH_QUOTE) lx_mode = PM_STRING;
					else if (c == CH_ZERO) begin ok = lx_push(c); lx_mode = PM_ZPREFIX; end
					else if (is_digit(c)) begin ok = lx_push(c); lx_mode = PM_DECIMAL; end
					else if (is_sym_start(c) || c == "&") begin
						ok = lx_push(c);
						lx_mode = PM_SYMBOL;
					end
					else if (c == CH_MINUS) begin ok = lx_push(c); lx_mode = PM_MINUS; end
					else if (c == CH_HASH) begin ok = lx_push(c); lx_mode = PM_HPREFIX; end
					else if (!is_term(c)) begin
						void'(lx_push(c));
						emit_token(TT_ERROR, lx_col);
					end
				end
				PM_MINUS: begin
					if (is_digit(c)) begin ok = lx_push(c); lx_mode = PM_DECIMAL; end
					else if (is_sym_start(c)) begin lx_mode = PM_SYMBOL; redo = 1; end
					else if (is_blank(c)) emit_token(TT_SYMBOL, lx_col);
					else begin void'(lx_push(c)); emit_token(TT_ERROR, lx_col); end
				end
				PM_ZPREFIX, PM_HPREFIX: begin
					if (c == CH_X_LO || c == CH_X_UP) ok = lx_push(c);
					else if (is_hex(c)) begin ok = lx_push(c); lx_mode = PM_HEX; end
					else if (lx_mode == PM_ZPREFIX && lx_len == 1 && is_term(c))
						emit_token(TT_INTEGER, lx_col);
					else begin void'(lx_push(c)); emit_token(TT_ERROR, lx_col); end
				end
				PM_DECIMAL, PM_HEX: begin
					if (is_term(c)) emit_token(TT_INTEGER, lx_col);
					else if (lx_mode == PM_DECIMAL ? is_digit(c) : is_hex(c)) ok = lx_push(c);
					else begin void'(lx_push(c)); emit_token(TT_ERROR, lx_col); end
				end
				PM_STRING: begin
					if (c == CH_QUOTE) emit_token(TT_STRING, lx_col);
					else if (c == CH_BSLASH) lx_mode = PM_ESCAPE;
					else ok = lx_push(c);
				end
				PM_ESCAPE: begin
					lx_mode = PM_STRING;
					case (c)
						CH_LF: ;
						CH_BSLASH, CH_QUOTE: ok = lx_push(c);
						"a": ok = lx_push(ESC_BEL);
						"b": ok = lx_push(ESC_BS);
						"f": ok = lx_push(ESC_FF);
						"n": ok = lx_push(ESC_LF);
						"r": ok = lx_push(ESC_CR);
						"t": ok = lx_push(ESC_HT);
						"v": ok = lx_push(ESC_VT);
						default: begin ok = lx_push(CH_BSLASH); redo = 1; end
					endcase
				end
				PM_SYMBOL: begin
					if (in_sym_set(c)) ok = lx_push(c);
					else begin emit_token(TT_SYMBOL, col_prev); redo = 1; end
				end
				default: begin
					lx_mode = PM_IDLE;
					lx_len = 0;
				end
			endcase
			if (!ok) begin
				emit_token(TT_ERROR, lx_col);
				redo = 0;
			end
		end
	endtask

	// Stimulus helpers
	task automatic add_char(logic [7:0] c);
		pending_items.push_back('{KIND_CHAR, c});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endtask

	task automatic add_eol();
		pending_items.push_back('{KIND_EOL, 8'($urandom)});
	endtask

	function automatic logic [7:0] pick_char();
		string pool;
		int r;
		pool = "0123456789abcdefxXAF-+*/<>=&!?@#\"\\ ntvr";
		r = $urandom_range(0, 99);
		if (r < 80) return pool[$urandom_range(0, pool.len() - 1)];
		if (r < 90) return 8'($urandom_range(128, 255));
		case ($urandom_range(0, 4))
			0: return CH_NUL;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_LF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Token with random content, well-formed but for the random-character kind, followed by a separator
	task automatic add_random_token();
		int n;
		string hex_pool, sym_first, sym_rest;
		logic [7:0] pc;
		n = $urandom_range(1, 6);
		hex_pool = "0123456789abcdefABCDEF";
		sym_first = "abcXYZ+*<=>/&";
		sym_rest = "az09!?@-+";
		case ($urandom_range(0, 5))
			0: begin
				if ($urandom_range(0, 1)) add_char(CH_MINUS);
				for (int i = 0; i < n; i++) add_char(8'("0" + $urandom_range(0, 9)));
			end
			1: begin
				add_char($urandom_range(0, 1) ? CH_ZERO : CH_HASH);
				add_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
				for (int i = 0; i < n; i++) add_char(hex_pool[$urandom_range(0, 21)]);
			end
			2: begin
				add_char(CH_QUOTE);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 3) == 0) add_char(CH_BSLASH);
					pc = pick_char();
					add_char(pc == CH_QUOTE ? "q" : pc);
				end
				add_char(CH_QUOTE);
			end
			3: begin
				add_char(sym_first[$urandom_range(0, 12)]);
				for (int i = 1; i < n; i++) add_char(sym_rest[$urandom_range(0, 8)]);
			end
			default: for (int i = 0; i < n; i++) add_char(pick_char());
		endcase
		case ($urandom_range(0, 5))
			0: add_eol();
			1: add_char(CH_TAB);
			2: add_char("(");
			default: add_char(CH_SPACE);
		endcase
	endtask

	// Driver: present queued transactions; hold the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= 1'b0;
			char_in  <= 8'd0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) items_sent <= items_sent + 1;
			if (pending_items.size() > 0 && !hold_sender &&
				$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				kind     <= pending_items[0].kind;
				char_in  <= pending_items[0].ch;
				predict_item(pending_items.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Monitor: compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		token_beat_t exp_b, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{tok_class, char_out, char_present, int_value, column, last};
			beats_checked++;
			if (got.last && got.tok_class != TT_EOL) tokens_seen++;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				failures++;
			end else begin
				exp_b = expected_beats.pop_front();
				if (got.tok_class !== exp_b.tok_class)
					$display("%0t: tok_class expected %0d actual %0d",
						$time, exp_b.tok_class, got.tok_class);
				if (got.char_out !== exp_b.char_out)
					$display("%0t: char_out expected %h actual %h",
						$time, exp_b.char_out, got.char_out);
				if (got.char_present !== exp_b.char_present)
					$display("%0t: char_present expected %b actual %b",
						$time, exp_b.char_present, got.char_present);
				if (got.int_value !== exp_b.int_value)
					$display("%0t: int_value expected %h actual %h",
						$time, exp_b.int_value, got.int_value);
				if (got.column !== exp_b.column)
					$display("%0t: column expected %0d actual %0d",
						$time, exp_b.column, got.column);
				if (got.last !== exp_b.last)
					$display("%0t: last expected %b actual %b",
						$time, exp_b.last, got.last);
				if (got !== exp_b) failures++;
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic drain_phase();
		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_beats.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		lx_mode = PM_IDLE;
		lx_len = 0;
		lx_col = 0;
		failures = 0;
		beats_checked = 0;
		items_sent = 0;
		tokens_seen = 0;
		quiet_cycles = 0;
		hold_sender = 0;
		send_idle_pct = 27;
		recv_idle_pct = 67;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: integers at the saturation edges, prefixes, lone zero
		add_text("2147483647 -2147483649 0 0x7fffffff #XFFFFFFFFF 0");
		add_eol();
		// strings with all letter, backslash and quote escapes, an empty string, escape fall-through
		add_text("\"\\a\\b\\f\\n\\r\\t\\v\\\\\\\"\\q\" \"\"");
		add_eol();
		// minus alone, minus then letter, symbol ended by a character lexed again
		add_text("- -ab foo(12x #g 0z -)");
		add_char(8'hFF);
		add_char(CH_NUL);
		add_eol();
		// prefix broken by a quote, then a symbol flushed at end of line
		add_text("#x\"ab");
		add_eol();
		// overflow: symbol longer than the token buffer
		for (int i = 0; i <= TOKEN_MAX; i++) add_char("k");
		add_eol();
		add_eol();
		drain_phase();

		// Random lines, three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 67 : 0;
			recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 27 : 0;
			while (pending_items.size() < 4) begin
				if ($urandom_range(0, 4) == 0) add_char(pick_char());
				else add_random_token();
			end
			add_eol();
			if (ph == 1) begin
				// pause the sender mid-phase until everything has drained
				while (pending_items.size() > 2) @(posedge clk);
				hold_sender = 1;
				while (in_valid || expected_beats.size() > 0) @(posedge clk);
				hold_sender = 0;
			end
			drain_phase();
		end

		$display("Covered %0d input transactions, %0d result transactions, %0d tokens,",
			items_sent, beats_checked, tokens_seen);
		$display("over directed edge cases and random lines in three idling phases.");
		if (failures == 0 && expected_beats.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ltl_pkg.sv
hdl/ltl_ctrl.sv
hdl/ltl_datapath.sv
hdl/lisp_token_lexer.sv
tb/sv/testbench.sv
